// ----- rtl/ssbg_pkg.sv -----
// Shared types, register codes and the quarter-wave sine builder for the
// stereo sine beep generator. No dependencies.
`timescale 1ns / 1ps

package ssbg_pkg;

   // Fixed field widths
   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 16;
   localparam int STEP_BITS   = 31;
   localparam int GAIN_BITS   = 16;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // Peak table value, 2^(SAMPLE_BITS-1) - 1
   localparam longint unsigned FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

   // Register index codes (byte address bits [3:2])
   typedef enum logic [1:0] {
      REG_PHASE_STEP     = 2'd0,
      REG_AMPLITUDE_GAIN = 2'd1,
      REG_BURST_LENGTH   = 2'd2
   } reg_index_type;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [STEP_BITS-1:0]  phase_step;
      logic [GAIN_BITS-1:0]  amplitude_gain;
      logic [INDEX_BITS-1:0] burst_length;
   } ssbg_cfg_type;

   // Per-sample flags carried alongside the table read
   typedef struct packed {
      logic active;
      logic last;
      logic negate;
   } ssbg_flags_type;

   // Table entry a of a quarter wave with 2^addr_bits steps: Q2.30 Taylor
   // series of sin(a*pi/(2N)) up to x^15, each term truncated, then scaled
   // to full scale with rounding. Evaluated at elaboration only.
   function automatic logic [SAMPLE_BITS-2:0] sine_mag(input int unsigned a,
                                                       input int unsigned addr_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned mag;
      x    = (longint'(a) * 64'd1686629713) >> addr_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
         sum = 64'sd1 <<< 30;
      end
      mag = (longint'(sum) * FULL_SCALE + (64'd1 << 29)) >> 30;
      return mag[SAMPLE_BITS-2:0];
   endfunction

endpackage

// ----- rtl/stereo_sine_beep_generator_top.sv -----
// Top level of the stereo sine beep generator: stream handshake and pipeline.
// Depends on ssbg_pkg, ssbg_csr, ssbg_phase, ssbg_rom and ssbg_scale.
`timescale 1ns / 1ps

// Each transfer on the req_ side is one sample tick; req_tdata bit 0 is the
// restart flag, which clears phase and count and begins a new burst on that
// tick. Each tick gives exactly one result transfer with the same sample on
// left and right, tlast on the final tone sample of a burst and tuser high
// while tone is playing (samples are zero when silent). The datapath is two
// register stages: the phase accumulator step and quarter-wave ROM read, then
// the gain multiply into the result register. A tick can be taken every clock
// cycle unless rsp_tready low stalls both stages, without losing data. The user
// must write the registers (phase_step, amplitude_gain, burst_length at byte
// addresses 0, 4, 8) only while idle; the block itself does not enforce this.
// The ROM is a constant table built at elaboration; no clearing pass is needed.

module stereo_sine_beep_generator_top #(
   parameter int PHASE_BITS      = 32,
   parameter int TABLE_ADDR_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // Tick channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [0] restart
   // Sample channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [2*ssbg_pkg::SAMPLE_BITS-1:0]  rsp_tdata,   // [15:0] left, [31:16] right
   output logic                                rsp_tlast,   // burst_last
   output logic                                rsp_tuser,   // [0] tone_active
   // Configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [ssbg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [ssbg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [ssbg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import ssbg_pkg::*;

   ssbg_cfg_type               cfg;
   ssbg_flags_type             flags;
   logic [TABLE_ADDR_BITS:0]   rom_index;
   logic [SAMPLE_BITS-2:0]     mag;
   logic [SAMPLE_BITS-1:0]     sample;
   logic                       s1_valid_ff, s1_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       out_free;
   logic                       s1_load;
   logic                       s2_load;

   // Pipeline handshake: a stage moves when the one after it is free
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = ~s1_valid_ff | out_free;
   assign s1_load    = req_tvalid & req_tready;
   assign s2_load    = s1_valid_ff & out_free;

   assign s1_valid_in  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s2_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   ssbg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ssbg_phase #(
      .PHASE_BITS      (PHASE_BITS),
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .load      (s1_load),
      .restart   (req_tdata[0]),
      .cfg       (cfg),
      .rom_index (rom_index),
      .flags_ff  (flags)
   );

   ssbg_rom #(
      .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
   ) u_rom (
      .clock     (clock),
      .load      (s1_load),
      .rom_index (rom_index),
      .mag_ff    (mag)
   );

   ssbg_scale u_scale (
      .clock     (clock),
      .load      (s2_load),
      .flags     (flags),
      .mag       (mag),
      .gain      (cfg.amplitude_gain),
      .sample_ff (sample),
      .last_ff   (rsp_tlast),
      .active_ff (rsp_tuser)
   );

   // Same sample on both channels
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {sample, sample};

endmodule

// ----- rtl/ssbg_csr.sv -----
// Configuration registers behind the APB-style port.
// Depends on ssbg_pkg.
`timescale 1ns / 1ps

module ssbg_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ssbg_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [ssbg_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [ssbg_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready,
   output ssbg_pkg::ssbg_cfg_type             cfg
);
   import ssbg_pkg::*;

   logic [STEP_BITS-1:0]  phase_step_ff;
   logic [GAIN_BITS-1:0]  gain_ff;
   logic [INDEX_BITS-1:0] length_ff;
   logic                  wr_en;
   reg_index_type         reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);

   // Register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= STEP_BITS'(118111601);
         gain_ff       <= GAIN_BITS'(19661);
         length_ff     <= INDEX_BITS'(1600);
      end else if (wr_en) begin
         case (reg_sel)
            REG_PHASE_STEP:     phase_step_ff <= csr_pwdata[STEP_BITS-1:0];
            REG_AMPLITUDE_GAIN: gain_ff       <= csr_pwdata[GAIN_BITS-1:0];
            REG_BURST_LENGTH:   length_ff     <= csr_pwdata[INDEX_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Read-back mux
   always_comb begin
      case (reg_sel)
         REG_PHASE_STEP:     csr_prdata = CSR_DATA_BITS'(phase_step_ff);
         REG_AMPLITUDE_GAIN: csr_prdata = CSR_DATA_BITS'(gain_ff);
         REG_BURST_LENGTH:   csr_prdata = CSR_DATA_BITS'(length_ff);
         default:            csr_prdata = '0;
      endcase
   end

   assign cfg.phase_step     = phase_step_ff;
   assign cfg.amplitude_gain = gain_ff;
   assign cfg.burst_length   = length_ff;

endmodule

// ----- rtl/ssbg_phase.sv -----
// Phase accumulator, burst counter and table address generation.
// Depends on ssbg_pkg.
`timescale 1ns / 1ps

module ssbg_phase #(
   parameter int PHASE_BITS      = 32,
   parameter int TABLE_ADDR_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic                         restart,
   input  ssbg_pkg::ssbg_cfg_type       cfg,
   output logic [TABLE_ADDR_BITS:0]     rom_index,
   output ssbg_pkg::ssbg_flags_type     flags_ff
);
   import ssbg_pkg::*;

   logic [PHASE_BITS-1:0]      phase_ff, phase_in, phase_cur;
   logic [INDEX_BITS-1:0]      index_ff, index_in, index_cur;
   logic                       running_ff, running_in;
   ssbg_flags_type             flags_in;
   logic                       run_cur;
   logic                       is_last;
   logic [1:0]                 quad;
   logic [TABLE_ADDR_BITS-1:0] addr;

   // Restart takes effect on its own tick
   assign phase_cur = restart ? '0 : phase_ff;
   assign index_cur = restart ? '0 : index_ff;
   assign run_cur   = restart | running_ff;

   assign is_last = ({1'b0, index_cur} + (INDEX_BITS + 1)'(1)) >= {1'b0, cfg.burst_length};

   // Quadrant and mirrored table address
   assign quad = phase_cur[PHASE_BITS-1 -: 2];
   assign addr = phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
   assign rom_index = quad[0] ? ({1'b1, {TABLE_ADDR_BITS{1'b0}}} - {1'b0, addr})
                              : {1'b0, addr};

   // Next state
   always_comb begin
      phase_in        = phase_ff;
      index_in        = index_ff;
      running_in      = running_ff;
      flags_in.active = run_cur;
      flags_in.last   = run_cur & is_last;
      flags_in.negate = quad[1];
      if (run_cur) begin
         phase_in   = phase_cur + PHASE_BITS'(cfg.phase_step);
         index_in   = index_cur + INDEX_BITS'(1);
         running_in = ~is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         index_ff   <= '0;
         running_ff <= 1'b0;
         flags_ff   <= '0;
      end else if (load) begin
         phase_ff   <= phase_in;
         index_ff   <= index_in;
         running_ff <= running_in;
         flags_ff   <= flags_in;
      end
   end

endmodule

// ----- rtl/ssbg_rom.sv -----
// Quarter-wave sine ROM with registered read, 2^TABLE_ADDR_BITS + 1 entries.
// Depends on ssbg_pkg (table builder).
`timescale 1ns / 1ps

module ssbg_rom #(
   parameter int TABLE_ADDR_BITS = 8
) (
   input  logic                               clock,
   input  logic                               load,
   input  logic [TABLE_ADDR_BITS:0]           rom_index,
   output logic [ssbg_pkg::SAMPLE_BITS-2:0]   mag_ff
);
   import ssbg_pkg::*;

   localparam int TABLE_SIZE = (1 << TABLE_ADDR_BITS) + 1;

   typedef logic [SAMPLE_BITS-2:0] rom_type [TABLE_SIZE];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int a = 0; a < TABLE_SIZE; a++) begin
         rom[a] = sine_mag(a, TABLE_ADDR_BITS);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Registered read, one entry per sample
   always_ff @(posedge clock) begin
      if (load) begin
         mag_ff <= SINE_ROM[rom_index];
      end
   end

endmodule

// ----- rtl/ssbg_scale.sv -----
// Amplitude scaling, sign and silence gating into the result register.
// Depends on ssbg_pkg.
`timescale 1ns / 1ps

module ssbg_scale (
   input  logic                                clock,
   input  logic                                load,
   input  ssbg_pkg::ssbg_flags_type            flags,
   input  logic [ssbg_pkg::SAMPLE_BITS-2:0]    mag,
   input  logic [ssbg_pkg::GAIN_BITS-1:0]      gain,
   output logic [ssbg_pkg::SAMPLE_BITS-1:0]    sample_ff,
   output logic                                last_ff,
   output logic                                active_ff
);
   import ssbg_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS - 1 + GAIN_BITS;

   logic [PROD_BITS-1:0]   product;
   logic [SAMPLE_BITS-2:0] scaled;
   logic [SAMPLE_BITS-1:0] sample_in;

   // Q0.16 gain, truncated toward zero before the sign is applied
   assign product = PROD_BITS'(mag) * PROD_BITS'(gain);
   assign scaled  = product[PROD_BITS-1 -: SAMPLE_BITS-1];

   always_comb begin
      if (!flags.active) begin
         sample_in = '0;
      end else if (flags.negate) begin
         sample_in = '0 - {1'b0, scaled};
      end else begin
         sample_in = {1'b0, scaled};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sample_ff <= sample_in;
         last_ff   <= flags.last;
         active_ff <= flags.active;
      end
   end

endmodule

// ----- verif/tb_stereo_sine_beep_generator_top.sv -----
// Self-checking testbench for the stereo sine beep generator: random-paced tick
// and sample streams, APB register writes with readback, and a cycle-free tone predictor.
// Depends on ssbg_pkg and stereo_sine_beep_generator_top.
`timescale 1ns / 1ps

module tb_stereo_sine_beep_generator_top;
   import ssbg_pkg::*;

   typedef longint unsigned u64_type;

   // Expected content of one sample transfer
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left;
      logic [SAMPLE_BITS-1:0] right;
      logic                   last;
      logic                   active;
   } tone_sample_type;

   localparam int QUARTER_STEPS = 256;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata = 8'd0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [2*SAMPLE_BITS-1:0]     rsp_tdata;
   logic                         rsp_tlast;
   logic                         rsp_tuser;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]     csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]     csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]     csr_prdata;
   logic                         csr_pready;

   // Predictor copy of the registers and the tone state
   logic [STEP_BITS-1:0]         cfg_step  = 31'd118111601;
   logic [GAIN_BITS-1:0]         cfg_gain  = 16'd19661;
   logic [INDEX_BITS-1:0]        cfg_burst = 16'd1600;
   logic [31:0]                  tone_phase = '0;
   logic [INDEX_BITS-1:0]        tone_index = '0;
   logic                         tone_running = 1'b0;
   logic [SAMPLE_BITS-1:0]       sine_quarter [0:QUARTER_STEPS];

   bit                           pending_ticks[$];
   tone_sample_type              expected_samples[$];
   int                           ticks_taken = 0;
   int                           ticks_seen = 0;
   int                           results_taken = 0;
   int                           results_seen = 0;
   int                           tick_gap = 0;
   int                           accept_gap = 0;
   int                           mismatches = 0;
   bit                           pacing_on = 1'b1;

   stereo_sine_beep_generator_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),     // [0] restart
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),     // [15:0] left, [31:16] right
      .rsp_tlast   (rsp_tlast),     // burst_last
      .rsp_tuser   (rsp_tuser),     // [0] tone_active
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Clock and a single reset pulse
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Overall time limit
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Quarter-wave table: truncated Taylor series in Q2.30, rounded to full scale
   initial begin : build_sine_quarter
      u64_type x;
      u64_type x2;
      u64_type term;
      longint acc;
      for (int a = 0; a <= QUARTER_STEPS; a++) begin
         x    = (u64_type'(a) * 64'd1686629713) >> 8;
         x2   = (x * x) >> 30;
         term = x;
         acc  = longint'(x);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * x2) >> 30) / u64_type'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         if (acc > (64'sd1 <<< 30)) begin
            acc = 64'sd1 <<< 30;
         end
         sine_quarter[a] = SAMPLE_BITS'((u64_type'(acc) * FULL_SCALE + (64'd1 << 29)) >> 30);
      end
   end

   // Advance the tone state by one tick and return the sample it yields
   function automatic tone_sample_type next_tone_sample(input logic restart);
      tone_sample_type s;
      logic [1:0]   quadrant;
      logic [7:0]   addr;
      logic [15:0]  mag;
      logic [31:0]  product;
      s = '0;
      if (restart) begin
         tone_phase   = '0;
         tone_index   = '0;
         tone_running = 1'b1;
      end
      if (tone_running) begin
         quadrant = tone_phase[31:30];
         addr     = tone_phase[29:22];
         mag      = quadrant[0] ? sine_quarter[9'd256 - {1'b0, addr}] : sine_quarter[addr];
         product  = 32'(mag) * 32'(cfg_gain);
         s.left   = quadrant[1] ? -product[31:16] : product[31:16];
         s.right  = s.left;
         s.active = 1'b1;
         if ({1'b0, tone_index} + 17'd1 >= {1'b0, cfg_burst}) begin
            s.last       = 1'b1;
            tone_running = 1'b0;
         end
         tone_phase = tone_phase + {1'b0, cfg_step};
         tone_index = tone_index + 16'd1;
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input u64_type got, input u64_type want);
      mismatches++;
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want, $time);
   endtask

   task automatic push_tick(input bit restart);
      pending_ticks.push_back(restart);
   endtask

   // Block idle: no tick queued or on the bus and every sample back
   task automatic wait_quiet();
      while (pending_ticks.size() != 0 || req_tvalid || expected_samples.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // APB write followed by a readback of the stored value
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      logic [31:0] stored;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_PHASE_STEP: begin
            cfg_step = value[STEP_BITS-1:0];
            stored   = {1'b0, cfg_step};
         end
         REG_AMPLITUDE_GAIN: begin
            cfg_gain = value[GAIN_BITS-1:0];
            stored   = {16'd0, cfg_gain};
         end
         default: begin
            cfg_burst = value[INDEX_BITS-1:0];
            stored    = {16'd0, cfg_burst};
         end
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== stored) begin
         report_mismatch("register readback", 64'(csr_prdata), 64'(stored));
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Tick driver: one queued tick per transfer, random gap before the next when pacing is on
   always @(negedge clock) begin : tick_driver
      logic       presenting;
      logic [7:0] data_next;
      presenting = req_tvalid;
      data_next  = req_tdata;
      if (reset) begin
         presenting = 1'b0;
         tick_gap   = 0;
      end else begin
         if (presenting && ticks_taken != ticks_seen) begin
            ticks_seen = ticks_taken;
            presenting = 1'b0;
            tick_gap   = pacing_on ? $urandom_range(0, 16) : 0;
         end
         if (!presenting) begin
            if (tick_gap != 0) begin
               tick_gap = tick_gap - 1;
            end else if (pending_ticks.size() != 0) begin
               data_next  = {7'd0, pending_ticks.pop_front()};
               presenting = 1'b1;
            end
         end
      end
      req_tvalid <= presenting;
      req_tdata  <= data_next;
   end

   // Sample sink: random stall after each accepted transfer when pacing is on
   always @(negedge clock) begin : sample_pacer
      if (!reset && rsp_tready && results_taken != results_seen) begin
         results_seen = results_taken;
         accept_gap   = pacing_on ? $urandom_range(0, 16) : 0;
      end
      if (accept_gap != 0) begin
         accept_gap = accept_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset;
      end
   end

   // Monitor: predict on each tick transfer, check each sample transfer
   always @(posedge clock) begin : stream_monitor
      tone_sample_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_samples.push_back(next_tone_sample(req_tdata[0]));
            ticks_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_taken++;
            if (expected_samples.size() == 0) begin
               report_mismatch("sample with no tick outstanding", 64'(rsp_tdata), 64'd0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_tdata[15:0] !== want.left) begin
                  report_mismatch("left_sample", 64'(rsp_tdata[15:0]), 64'(want.left));
               end
               if (rsp_tdata[31:16] !== want.right) begin
                  report_mismatch("right_sample", 64'(rsp_tdata[31:16]), 64'(want.right));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch("burst_last", 64'(rsp_tlast), 64'(want.last));
               end
               if (rsp_tuser !== want.active) begin
                  report_mismatch("tone_active", 64'(rsp_tuser), 64'(want.active));
               end
            end
         end
      end
   end

   // Stimulus
   initial begin : stimulus
      logic [31:0] v;
      while (reset) @(posedge clock);

      // Silence straight out of reset
      push_tick(1'b0);
      push_tick(1'b0);
      wait_quiet();

      // Quarter-turn step visits every quadrant boundary at full gain
      write_register(REG_BURST_LENGTH, 32'd4);
      write_register(REG_AMPLITUDE_GAIN, 32'hFFFF_FFFF);
      write_register(REG_PHASE_STEP, 32'h4000_0000);
      push_tick(1'b1);
      repeat (4) push_tick(1'b0);
      wait_quiet();

      // Widest step wraps the accumulator; bit 31 of the write is dropped
      write_register(REG_PHASE_STEP, 32'hFFFF_FFFF);
      write_register(REG_BURST_LENGTH, 32'd5);
      push_tick(1'b1);
      repeat (5) push_tick(1'b0);
      wait_quiet();

      // Zero length behaves as a one-sample burst; zero gain keeps tone flagged
      write_register(REG_BURST_LENGTH, 32'd0);
      write_register(REG_AMPLITUDE_GAIN, 32'd0);
      push_tick(1'b1);
      push_tick(1'b0);
      wait_quiet();

      // Length lowered while a burst is running ends it on the next sample
      write_register(REG_BURST_LENGTH, 32'd1000);
      write_register(REG_AMPLITUDE_GAIN, 32'h0000_8000);
      write_register(REG_PHASE_STEP, 32'h0123_4567);
      push_tick(1'b1);
      push_tick(1'b0);
      push_tick(1'b0);
      wait_quiet();
      write_register(REG_BURST_LENGTH, 32'd2);
      push_tick(1'b0);
      push_tick(1'b0);
      wait_quiet();

      // Restart abandons a running burst
      write_register(REG_BURST_LENGTH, 32'd8);
      push_tick(1'b1);
      push_tick(1'b0);
      push_tick(1'b1);
      push_tick(1'b0);
      push_tick(1'b0);

      // Random phases: fresh settings, then ticks with occasional restarts
      for (int p = 0; p < 10; p++) begin
         wait_quiet();
         pacing_on = (p % 3) != 2;
         if (p == 0 || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0:       v = 32'd0;
               1:       v = 32'h7FFF_FFFF;
               2:       v = $urandom;
               default: v = $urandom_range(0, 32'h0400_0000);
            endcase
            v[31] = 1'($urandom_range(0, 1));
            write_register(REG_PHASE_STEP, v);
         end
         if (p == 0 || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0:       v = 32'd0;
               1:       v = 32'd65535;
               default: v = $urandom_range(0, 65535);
            endcase
            v[31:16] = 16'($urandom);
            write_register(REG_AMPLITUDE_GAIN, v);
         end
         if (p == 0 || $urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0:       v = 32'd0;
               1:       v = 32'd1;
               2:       v = 32'd65535;
               3:       v = $urandom_range(1, 300);
               default: v = $urandom_range(1, 40);
            endcase
            v[31:16] = 16'($urandom);
            write_register(REG_BURST_LENGTH, v);
         end
         for (int n = 0; n < 58; n++) begin
            push_tick((n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 15) == 0));
         end
      end

      // Drain and let any stray sample show up
      wait_quiet();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/ssbg_pkg.sv
rtl/ssbg_csr.sv
rtl/ssbg_phase.sv
rtl/ssbg_rom.sv
rtl/ssbg_scale.sv
rtl/stereo_sine_beep_generator_top.sv
verif/tb_stereo_sine_beep_generator_top.sv
